[sv/ir_pulse_width_frame_decoder_defines.svh]
// assertion macros shared by the decoder checker
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH

// property checked on every clock edge outside reset
`define IRDEC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define IRDEC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/irdec_pkg.sv]
// shared types, constants and key map of the ir frame decoder
`timescale 1ns / 1ps
package irdec_pkg;

   localparam int FRAME_LEN_DEF = 12;
   localparam int MAP_DEPTH     = 128;

   localparam int COUNT_W  = 24;
   localparam int CHAR_W   = 7;
   localparam int KEY_W    = 7;
   localparam int MODE_W   = 5;
   localparam int MODE_LSB = 7;

   // class k covers counts with k*DEN <= counts*NUM < (k+1)*DEN
   localparam int CLASS_NUM = 24;
   localparam int CLASS_DEN = 1000000;
   localparam logic [COUNT_W-1:0] CLASS1_MIN =
      COUNT_W'((1 * CLASS_DEN + CLASS_NUM - 1) / CLASS_NUM);
   localparam logic [COUNT_W-1:0] CLASS2_MIN =
      COUNT_W'((2 * CLASS_DEN + CLASS_NUM - 1) / CLASS_NUM);
   localparam logic [COUNT_W-1:0] CLASS3_MIN =
      COUNT_W'((3 * CLASS_DEN + CLASS_NUM - 1) / CLASS_NUM);

   localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ACCEPTED_MODE = 1'b0;

   localparam logic [KEY_W-1:0] KEY_ENTER = KEY_W'(8'h0B);
   localparam logic [KEY_W-1:0] KEY_CLEAR = KEY_W'(8'h3B);

   typedef struct packed {
      logic start;
      logic one;
      logic zero;
   } pulse_class_type;

   function automatic logic [CHAR_W-1:0] key_to_char(input logic [KEY_W-1:0] key);
      logic [CHAR_W-1:0] ch;
      case (key)
         KEY_W'(8'h00): ch = CHAR_W'(8'h31);  // '1'
         KEY_W'(8'h01): ch = CHAR_W'(8'h32);
         KEY_W'(8'h02): ch = CHAR_W'(8'h33);
         KEY_W'(8'h03): ch = CHAR_W'(8'h34);
         KEY_W'(8'h04): ch = CHAR_W'(8'h35);
         KEY_W'(8'h05): ch = CHAR_W'(8'h36);
         KEY_W'(8'h06): ch = CHAR_W'(8'h37);
         KEY_W'(8'h07): ch = CHAR_W'(8'h38);
         KEY_W'(8'h08): ch = CHAR_W'(8'h39);
         KEY_W'(8'h09): ch = CHAR_W'(8'h30);  // '0'
         KEY_ENTER:     ch = CHAR_W'(8'h0A);  // newline
         KEY_W'(8'h10): ch = CHAR_W'(8'h5E);  // '^'
         KEY_W'(8'h11): ch = CHAR_W'(8'h76);  // 'v'
         KEY_W'(8'h12): ch = CHAR_W'(8'h2B);  // '+'
         KEY_W'(8'h13): ch = CHAR_W'(8'h2D);  // '-'
         KEY_W'(8'h14): ch = CHAR_W'(8'h6D);  // 'm'
         KEY_W'(8'h15): ch = CHAR_W'(8'h70);  // 'p'
         KEY_CLEAR:     ch = CHAR_W'(8'h63);  // 'c'
         default:       ch = '0;
      endcase
      return ch;
   endfunction

endpackage

[sv/irdec_classifier.sv]
// sorts a pulse length into zero, one or start mark; longer pulses match none
`timescale 1ns / 1ps
module irdec_classifier
   import irdec_pkg::*;
(
   input  logic [COUNT_W-1:0] pulse_counts,
   output pulse_class_type    pulse_class
);

   always_comb begin
      pulse_class.zero  = pulse_counts < CLASS1_MIN;
      pulse_class.one   = (pulse_counts >= CLASS1_MIN) && (pulse_counts < CLASS2_MIN);
      pulse_class.start = (pulse_counts >= CLASS2_MIN) && (pulse_counts < CLASS3_MIN);
   end

endmodule

[sv/irdec_frame.sv]
// frame assembly state and key lookup
`timescale 1ns / 1ps
module irdec_frame
   import irdec_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  pulse_class_type   pulse_class,
   input  logic [MODE_W-1:0] accepted_mode,
   output logic              emit,
   output logic [CHAR_W-1:0] key_char
);

   localparam int POS_W  = $clog2(FRAME_LEN + 1);
   localparam int EXT_W  = MODE_LSB + MODE_W;
   localparam int WIDE_W = (FRAME_LEN > EXT_W) ? FRAME_LEN : EXT_W;

   logic [FRAME_LEN-1:0] bits_ff, bits_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 open_ff, open_in;
   logic [WIDE_W-1:0]    wide_bits;
   logic                 done;

   always_comb begin
      bits_in = bits_ff;
      pos_in  = pos_ff;
      open_in = open_ff;
      if (pulse_class.start) begin
         bits_in = '0;
         pos_in  = '0;
         open_in = 1'b1;
      end else if ((pulse_class.zero || pulse_class.one) && open_ff) begin
         if (pulse_class.one) begin
            bits_in = bits_ff | (FRAME_LEN'(1) << pos_ff);
         end
         pos_in = pos_ff + POS_W'(1);
      end

      // bits past the frame length read as zero
      wide_bits = WIDE_W'(bits_in);
      done      = pos_in == POS_W'(FRAME_LEN);
      emit      = done && (wide_bits[MODE_LSB +: MODE_W] == accepted_mode);
      key_char  = key_to_char(wide_bits[KEY_W-1:0]);
      if (done) begin
         open_in = 1'b0;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         pos_ff  <= '0;
         open_ff <= 1'b0;
      end else if (advance) begin
         bits_ff <= bits_in;
         pos_ff  <= pos_in;
         open_ff <= open_in;
      end
   end

endmodule

[sv/irdec_csr.sv]
// register port holding the accepted mode
`timescale 1ns / 1ps
module irdec_csr
   import irdec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [MODE_W-1:0]     accepted_mode
);

   logic [MODE_W-1:0] mode_ff;
   logic              reg_index;

   assign reg_index     = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready    = 1'b1;
   assign accepted_mode = mode_ff;

   always_comb begin
      case (reg_index)
         REG_ACCEPTED_MODE: csr_prdata = CSR_DATA_W'(mode_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && reg_index == REG_ACCEPTED_MODE) begin
         mode_ff <= csr_pwdata[MODE_W-1:0];
      end
   end

endmodule

[sv/ir_pulse_width_frame_decoder.sv]
// top level of the ir pulse-width frame decoder
// Usage:
//   req channel carries one measured low-pulse length per request (req_pulse_counts).
//   rsp channel returns one character (rsp_key_char) for each completed frame whose
//   mode matches the accepted mode; other pulses produce nothing.
//   csr port holds the accepted mode at byte address 0, reset value 1; write it only
//   while no request is in flight.
// Path: a taken request is held in the input register; when the result register is
//   free, its character is registered there for an emitting frame and shown on rsp_valid.
// Throughput: one request per cycle unless a full result register stalls. The input
//   register and the frame logic with its result register each hold one request, so
//   the next request is taken while a result waits.
// Stall: when rsp_ready is low and the result register is full, the request in the
//   input register waits there and req_ready drops until the result is taken.
// Reset: synchronous; clears both valid bits, the frame state (no frame open) and
//   sets the accepted mode back to 1.
`timescale 1ns / 1ps
module ir_pulse_width_frame_decoder
   import irdec_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COUNT_W-1:0]    req_pulse_counts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_key_char,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic                in_valid_ff;
   logic [COUNT_W-1:0]  counts_ff;
   logic                out_valid_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic                advance;
   logic                emit;
   logic [CHAR_W-1:0]   key_char;
   logic [MODE_W-1:0]   accepted_mode;
   pulse_class_type     pulse_class;

   // the held request moves on when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid    = out_valid_ff;
   assign rsp_key_char = char_ff;

   irdec_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .accepted_mode (accepted_mode)
   );

   irdec_classifier u_classifier (
      .pulse_counts (counts_ff),
      .pulse_class  (pulse_class)
   );

   irdec_frame #(
      .FRAME_LEN (FRAME_LEN)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .pulse_class   (pulse_class),
      .accepted_mode (accepted_mode),
      .emit          (emit),
      .key_char      (key_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         counts_ff <= req_pulse_counts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         char_ff <= key_char;
      end
   end

endmodule

[sv/irdec_checker.sv]
// port-level checks for the ir frame decoder and their bind
`timescale 1ns / 1ps
`include "ir_pulse_width_frame_decoder_defines.svh"
module irdec_checker
   import irdec_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CHAR_W-1:0]     rsp_key_char,
   input logic                  csr_pready
);

   // a stalled response keeps its character
   `IRDEC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_char), "response changed while stalled")

   // a fresh response follows a request that went through the input and result registers without a stall
   `IRDEC_ASSERT(a_rsp_latency, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "response without a matching request")

   // reset empties the result register
   `IRDEC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response valid after reset")

   // register port never inserts wait states
   `IRDEC_ASSERT(a_pready_high, clock, reset, csr_pready, "register port not ready")

endmodule

bind ir_pulse_width_frame_decoder irdec_checker u_irdec_checker (.*);
